/* rtl/core/sfa_pkg.sv */
`timescale 1ns / 1ps

package sfa_pkg;

    localparam int MAX_PARTICLES = 65536;
    localparam int TABLE_BITS    = 10;
    localparam int POS_BITS      = 16;

    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam int WAVE_W     = 12;
    localparam int POS_W      = 16;
    localparam int IDX_W      = TABLE_BITS + 2;
    localparam int TAB_SIZE   = (1 << TABLE_BITS) + 1;
    localparam int TAB_W      = 15;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 33;
    localparam int MAG_W      = 32;
    localparam int SQ_W       = 64;
    localparam int CNT_W      = 17;
    localparam int DIV_W      = CNT_W + 14;
    localparam int STEP_W     = 6;
    localparam int FACTOR_W   = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [IDX_W-1:0] phase_t;

    typedef struct packed {
        phase_t [AXES-1:0] phase;
        logic              last;
    } item_t;

    typedef logic [TAB_W-1:0] tab_t [0:TAB_SIZE-1];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_ACC,
        ST_COUNT,
        ST_WAIT_OUT,
        ST_SQ_C,
        ST_SQ_S,
        ST_SUM,
        ST_DIV,
        ST_STORE,
        ST_FIN
    } back_state_t;

    // shift-subtract quotient, only evaluated while building the table
    function automatic longint unsigned div_u64(longint unsigned num,
                                                longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Q30 Taylor series of sin over a quarter wave, rounded to Q15
    function automatic tab_t build_sin_tab();
        tab_t t;
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint s;
        longint r;
        for (int i = 0; i < TAB_SIZE; i++)
        begin
            theta = (HALF_PI_Q30 * 64'(unsigned'(i))) >> TABLE_BITS;
            x2    = (theta * theta) >> 30;
            term  = theta;
            s     = longint'(theta);
            for (int n = 1; n <= 10; n++)
            begin
                den  = 64'(unsigned'((2 * n) * (2 * n + 1)));
                term = div_u64((term * x2) >> 30, den);
                if ((n & 1) == 1)
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
            end
            if (s < 0)
                s = 0;
            r = (s + 16384) >>> 15;
            if (r > 32767)
                r = 32767;
            t[i] = r[TAB_W-1:0];
        end
        return t;
    endfunction

    localparam tab_t SIN_TAB = build_sin_tab();

endpackage

/* rtl/core/sfa_front.sv */
`timescale 1ns / 1ps

module sfa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfa_pkg::WAVE_W-1:0]    cfg_data,
    input  logic [sfa_pkg::POS_W-1:0]     pos_x,
    input  logic [sfa_pkg::POS_W-1:0]     pos_y,
    input  logic [sfa_pkg::POS_W-1:0]     pos_z,
    input  logic                          last,
    output sfa_pkg::item_t                item
);

    localparam int PROD_W = sfa_pkg::WAVE_W + sfa_pkg::POS_W;

    logic [sfa_pkg::WAVE_W-1:0] wave_reg;
    logic [sfa_pkg::POS_W-1:0]  pos [sfa_pkg::AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wave_reg <= sfa_pkg::WAVE_W'(1);
        else if (cfg_we)
            wave_reg <= cfg_data;
    end

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    // phase = wave * pos mod 1, top TABLE_BITS+2 bits
    for (genvar a = 0; a < sfa_pkg::AXES; a++)
    begin : g_axis
        logic [PROD_W-1:0]            prod;
        logic [sfa_pkg::POS_BITS-1:0] ph;
        assign prod = PROD_W'(wave_reg) * PROD_W'(pos[a]);
        assign ph   = prod[sfa_pkg::POS_BITS-1:0];
        if (sfa_pkg::POS_BITS >= sfa_pkg::IDX_W)
        begin : g_trunc
            assign item.phase[a] = ph[sfa_pkg::POS_BITS-1 -: sfa_pkg::IDX_W];
        end
        else
        begin : g_pad
            assign item.phase[a] =
                {ph, {(sfa_pkg::IDX_W - sfa_pkg::POS_BITS){1'b0}}};
        end
    end

    assign item.last = last;

endmodule

/* rtl/core/sfa_fifo.sv */
`timescale 1ns / 1ps

module sfa_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfa_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output sfa_pkg::item_t pop_item,
    output logic           empty
);

    sfa_pkg::item_t                mem_reg [sfa_pkg::FIFO_DEPTH];
    logic [sfa_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [sfa_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [sfa_pkg::FIFO_AW:0]     count_reg;

    assign full     = (count_reg == (sfa_pkg::FIFO_AW + 1)'(sfa_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + 1'b1;
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* rtl/core/sfa_back.sv */
`timescale 1ns / 1ps

module sfa_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  sfa_pkg::item_t                  item,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sfa_pkg::FACTOR_W-1:0]    factor_x,
    output logic [sfa_pkg::FACTOR_W-1:0]    factor_y,
    output logic [sfa_pkg::FACTOR_W-1:0]    factor_z
);

    localparam int M = 1 << sfa_pkg::TABLE_BITS;

    sfa_pkg::back_state_t state_reg, state_next;

    sfa_pkg::item_t                      cur_reg;
    logic [sfa_pkg::AXIS_W-1:0]          axis_reg;
    logic [sfa_pkg::TAB_W-1:0]           tab_a_reg;
    logic [sfa_pkg::TAB_W-1:0]           tab_b_reg;
    logic [1:0]                          quad_reg;
    logic signed [sfa_pkg::SUM_W-1:0]    cos_sum_reg [sfa_pkg::AXES];
    logic signed [sfa_pkg::SUM_W-1:0]    sin_sum_reg [sfa_pkg::AXES];
    logic [sfa_pkg::CNT_W-1:0]           count_reg;
    logic [sfa_pkg::SQ_W-1:0]            sq_c_reg;
    logic [sfa_pkg::SQ_W-1:0]            sq_s_reg;
    logic [sfa_pkg::MAG_W-1:0]           rem_reg;
    logic [sfa_pkg::SQ_W-1:0]            quo_reg;
    logic [sfa_pkg::DIV_W-1:0]           div_d_reg;
    logic [sfa_pkg::STEP_W-1:0]          step_reg;
    logic [sfa_pkg::FACTOR_W-1:0]        factor_reg [sfa_pkg::AXES];
    logic                                out_valid_reg;

    logic                                can_count;
    logic                                last_axis;
    logic [sfa_pkg::TABLE_BITS-1:0]      j;
    logic [sfa_pkg::TABLE_BITS:0]        j_mirror;
    logic signed [sfa_pkg::VAL_W-1:0]    ta;
    logic signed [sfa_pkg::VAL_W-1:0]    tb;
    logic signed [sfa_pkg::VAL_W-1:0]    cval;
    logic signed [sfa_pkg::VAL_W-1:0]    sval;
    logic signed [sfa_pkg::SUM_W-1:0]    c_sum;
    logic signed [sfa_pkg::SUM_W-1:0]    s_sum;
    logic [sfa_pkg::SUM_W-1:0]           c_neg;
    logic [sfa_pkg::SUM_W-1:0]           s_neg;
    logic [sfa_pkg::MAG_W-1:0]           c_mag;
    logic [sfa_pkg::MAG_W-1:0]           s_mag;
    logic [sfa_pkg::DIV_W-1:0]           d_val;
    logic [sfa_pkg::MAG_W-1:0]           rem_sh;
    logic                                ge;
    logic [sfa_pkg::FACTOR_W-1:0]        sat_q;

    assign can_count = (count_reg < sfa_pkg::CNT_W'(sfa_pkg::MAX_PARTICLES));
    assign last_axis = (axis_reg == sfa_pkg::AXIS_W'(sfa_pkg::AXES - 1));

    // quadrant folding of the quarter-wave table
    assign j        = cur_reg.phase[axis_reg][sfa_pkg::TABLE_BITS-1:0];
    assign j_mirror = (sfa_pkg::TABLE_BITS + 1)'(M) - (sfa_pkg::TABLE_BITS + 1)'(j);
    assign ta       = sfa_pkg::VAL_W'(tab_a_reg);
    assign tb       = sfa_pkg::VAL_W'(tab_b_reg);

    always_comb
    begin
        case (quad_reg)
            2'd0:    begin sval = ta;  cval = tb;  end
            2'd1:    begin sval = tb;  cval = -ta; end
            2'd2:    begin sval = -ta; cval = -tb; end
            default: begin sval = -tb; cval = ta;  end
        endcase
    end

    assign c_sum = cos_sum_reg[axis_reg];
    assign s_sum = sin_sum_reg[axis_reg];
    assign c_neg = -c_sum;
    assign s_neg = -s_sum;
    assign c_mag = c_sum[sfa_pkg::SUM_W-1] ? c_neg[sfa_pkg::MAG_W-1:0]
                                           : c_sum[sfa_pkg::MAG_W-1:0];
    assign s_mag = s_sum[sfa_pkg::SUM_W-1] ? s_neg[sfa_pkg::MAG_W-1:0]
                                           : s_sum[sfa_pkg::MAG_W-1:0];
    assign d_val = {count_reg, 14'd0};

    // one restoring divide step per cycle
    assign rem_sh = {rem_reg[sfa_pkg::MAG_W-2:0], quo_reg[sfa_pkg::SQ_W-1]};
    assign ge     = (rem_sh >= sfa_pkg::MAG_W'(div_d_reg));
    assign sat_q  = (quo_reg[sfa_pkg::SQ_W-1:sfa_pkg::FACTOR_W] != '0) ? '1
                  : quo_reg[sfa_pkg::FACTOR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfa_pkg::ST_IDLE:
                if (!empty)
                begin
                    if (can_count)
                        state_next = sfa_pkg::ST_LOOK;
                    else if (item.last)
                        state_next = sfa_pkg::ST_WAIT_OUT;
                end
            sfa_pkg::ST_LOOK:
                state_next = sfa_pkg::ST_ACC;
            sfa_pkg::ST_ACC:
                state_next = last_axis ? sfa_pkg::ST_COUNT : sfa_pkg::ST_LOOK;
            sfa_pkg::ST_COUNT:
                state_next = cur_reg.last ? sfa_pkg::ST_WAIT_OUT : sfa_pkg::ST_IDLE;
            sfa_pkg::ST_WAIT_OUT:
                if (!out_valid_reg)
                    state_next = sfa_pkg::ST_SQ_C;
            sfa_pkg::ST_SQ_C:
                state_next = sfa_pkg::ST_SQ_S;
            sfa_pkg::ST_SQ_S:
                state_next = sfa_pkg::ST_SUM;
            sfa_pkg::ST_SUM:
                state_next = sfa_pkg::ST_DIV;
            sfa_pkg::ST_DIV:
                if (step_reg == '1)
                    state_next = sfa_pkg::ST_STORE;
            sfa_pkg::ST_STORE:
                state_next = last_axis ? sfa_pkg::ST_FIN : sfa_pkg::ST_SQ_C;
            sfa_pkg::ST_FIN:
                state_next = sfa_pkg::ST_IDLE;
            default:
                state_next = sfa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            sfa_pkg::ST_IDLE: pop = !empty;
            default:          pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sfa_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < sfa_pkg::AXES; a++)
            begin
                cos_sum_reg[a] <= '0;
                sin_sum_reg[a] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                sfa_pkg::ST_ACC:
                begin
                    cos_sum_reg[axis_reg] <= c_sum + sfa_pkg::SUM_W'(cval);
                    sin_sum_reg[axis_reg] <= s_sum + sfa_pkg::SUM_W'(sval);
                end
                sfa_pkg::ST_COUNT:
                    count_reg <= count_reg + 1'b1;
                sfa_pkg::ST_FIN:
                begin
                    out_valid_reg <= 1'b1;
                    count_reg     <= '0;
                    for (int a = 0; a < sfa_pkg::AXES; a++)
                    begin
                        cos_sum_reg[a] <= '0;
                        sin_sum_reg[a] <= '0;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sfa_pkg::ST_IDLE:
            begin
                cur_reg  <= item;
                axis_reg <= '0;
            end
            sfa_pkg::ST_LOOK:
            begin
                tab_a_reg <= sfa_pkg::SIN_TAB[{1'b0, j}];
                tab_b_reg <= sfa_pkg::SIN_TAB[j_mirror];
                quad_reg  <= cur_reg.phase[axis_reg][sfa_pkg::IDX_W-1 -: 2];
            end
            sfa_pkg::ST_ACC:
                if (!last_axis)
                    axis_reg <= axis_reg + 1'b1;
            sfa_pkg::ST_WAIT_OUT:
                axis_reg <= '0;
            sfa_pkg::ST_SQ_C:
                sq_c_reg <= sfa_pkg::SQ_W'(c_mag) * sfa_pkg::SQ_W'(c_mag);
            sfa_pkg::ST_SQ_S:
                sq_s_reg <= sfa_pkg::SQ_W'(s_mag) * sfa_pkg::SQ_W'(s_mag);
            sfa_pkg::ST_SUM:
            begin
                quo_reg   <= sq_c_reg + sq_s_reg + sfa_pkg::SQ_W'(d_val >> 1);
                rem_reg   <= '0;
                div_d_reg <= d_val;
                step_reg  <= '0;
            end
            sfa_pkg::ST_DIV:
            begin
                rem_reg  <= ge ? rem_sh - sfa_pkg::MAG_W'(div_d_reg) : rem_sh;
                quo_reg  <= {quo_reg[sfa_pkg::SQ_W-2:0], ge};
                step_reg <= step_reg + 1'b1;
            end
            sfa_pkg::ST_STORE:
            begin
                factor_reg[axis_reg] <= (count_reg == '0) ? '0 : sat_q;
                if (!last_axis)
                    axis_reg <= axis_reg + 1'b1;
            end
            default:
                ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign factor_x  = factor_reg[0];
    assign factor_y  = factor_reg[1];
    assign factor_z  = factor_reg[2];

endmodule

/* rtl/core/structure_factor_accumulator.sv */
`timescale 1ns / 1ps

// Static structure factor |sum exp(i k x)|^2 / N along x, y and z.
// Input channel in_valid/in_ready carries one particle per request:
// pos_x/pos_y/pos_z as box fractions and last on the final particle.
// Output channel out_valid/out_ready carries factor_x/y/z, Q16.16,
// saturating, one request per configuration (after each last).
// cfg_we/cfg_data write wave_multiple (reset 1); write only while idle.
// The front stage computes phases and pushes into a 4-deep queue; the
// back end does one axis at a time, a table read plus accumulate for
// each particle. A last particle then adds, for each axis, two 32x32
// squares, an add and a 64-step one-bit-per-cycle divider.
// In_ready drops only when the queue is full. The result sits in an
// output register; if the receiver stalls, particles keep flowing until
// the next last, which waits for the register to be taken.
// Reset clears sums, count, queue and output valid; no clearing pass.
module structure_factor_accumulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfa_pkg::WAVE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sfa_pkg::POS_W-1:0]     pos_x,
    input  logic [sfa_pkg::POS_W-1:0]     pos_y,
    input  logic [sfa_pkg::POS_W-1:0]     pos_z,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sfa_pkg::FACTOR_W-1:0]  factor_x,
    output logic [sfa_pkg::FACTOR_W-1:0]  factor_y,
    output logic [sfa_pkg::FACTOR_W-1:0]  factor_z
);

    sfa_pkg::item_t front_item;
    sfa_pkg::item_t queue_item;
    logic           full;
    logic           empty;
    logic           pop;

    sfa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .last     (last),
        .item     (front_item)
    );

    sfa_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (front_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (queue_item),
        .empty     (empty)
    );

    sfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .item      (queue_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .factor_x  (factor_x),
        .factor_y  (factor_y),
        .factor_z  (factor_z)
    );

    assign in_ready = !full;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int QUARTER   = 1 << sfa_pkg::TABLE_BITS;
    localparam int DRAIN     = 300;
    localparam int STALL_MAX = 20000;

    typedef struct {
        logic [sfa_pkg::POS_W-1:0] px;
        logic [sfa_pkg::POS_W-1:0] py;
        logic [sfa_pkg::POS_W-1:0] pz;
        logic                      lst;
    } particle_t;

    typedef struct {
        logic [sfa_pkg::FACTOR_W-1:0] fx;
        logic [sfa_pkg::FACTOR_W-1:0] fy;
        logic [sfa_pkg::FACTOR_W-1:0] fz;
    } factors_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [sfa_pkg::WAVE_W-1:0]   cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [sfa_pkg::POS_W-1:0]    pos_x;
    logic [sfa_pkg::POS_W-1:0]    pos_y;
    logic [sfa_pkg::POS_W-1:0]    pos_z;
    logic                         last;
    logic                         out_valid;
    logic                         out_ready;
    logic [sfa_pkg::FACTOR_W-1:0] factor_x;
    logic [sfa_pkg::FACTOR_W-1:0] factor_y;
    logic [sfa_pkg::FACTOR_W-1:0] factor_z;

    structure_factor_accumulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .factor_x  (factor_x),
        .factor_y  (factor_y),
        .factor_z  (factor_z)
    );

    // predictor state
    int             sin_q15 [0:QUARTER];
    logic [11:0]    wave_mult;
    longint         cos_acc [3];
    longint         sin_acc [3];
    int unsigned    part_cnt;

    particle_t      particle_q [$];
    factors_t       factor_q [$];

    int             errors;
    int             particles_sent;
    int             results_seen;
    int             waves_written;
    bit             in_took;
    int             burst_left;
    int             gap_left;
    int             rx_mode;
    int             rx_cyc;
    int             idle_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void build_sine();
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          r;
        for (int i = 0; i <= QUARTER; i++)
        begin
            theta = (64'd1686629713 * longint'(i)) >> sfa_pkg::TABLE_BITS;
            x2    = (theta * theta) >> 30;
            term  = theta;
            acc   = longint'(theta);
            for (int n = 1; n <= 10; n++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            r = (acc + 16384) >>> 15;
            if (r > 32767)
                r = 32767;
            sin_q15[i] = int'(r);
        end
    endfunction

    function automatic void phase_lookup(input logic [sfa_pkg::POS_W-1:0] pos,
                                         output int c, output int s);
        logic [27:0] prod;
        logic [11:0] idx;
        int          a;
        int          b;
        prod = wave_mult * pos;
        idx  = prod[15:4];
        a    = sin_q15[idx[9:0]];
        b    = sin_q15[QUARTER - idx[9:0]];
        case (idx[11:10])
            2'd0: begin s = a;  c = b;  end
            2'd1: begin s = b;  c = -a; end
            2'd2: begin s = -a; c = -b; end
            default: begin s = -b; c = a; end
        endcase
    endfunction

    function automatic logic [31:0] axis_factor(input longint cs, input longint ss,
                                                input int unsigned n);
        longint unsigned ca;
        longint unsigned sa;
        longint unsigned x;
        longint unsigned d;
        longint unsigned q;
        ca = (cs < 0) ? -cs : cs;
        sa = (ss < 0) ? -ss : ss;
        x  = ca * ca + sa * sa;
        d  = longint'(n) << 14;
        if (d == 0)
            return 32'd0;
        q = (x + d / 2) / d;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic void accumulate_particle(input particle_t p);
        int       c;
        int       s;
        factors_t f;
        logic [sfa_pkg::POS_W-1:0] pos [3];
        logic [31:0]               res [3];
        pos[0] = p.px;
        pos[1] = p.py;
        pos[2] = p.pz;
        if (part_cnt < sfa_pkg::MAX_PARTICLES)
        begin
            for (int a = 0; a < 3; a++)
            begin
                phase_lookup(pos[a], c, s);
                cos_acc[a] += c;
                sin_acc[a] += s;
            end
            part_cnt++;
        end
        if (p.lst)
        begin
            for (int a = 0; a < 3; a++)
            begin
                res[a] = axis_factor(cos_acc[a], sin_acc[a], part_cnt);
                cos_acc[a] = 0;
                sin_acc[a] = 0;
            end
            part_cnt = 0;
            f.fx = res[0];
            f.fy = res[1];
            f.fz = res[2];
            factor_q = {factor_q, f};
        end
    endfunction

    // monitor: predict on accepted requests, check results
    always @(posedge clk)
    begin
        factors_t e;
        in_took = in_valid && in_ready && rst_n;
        if (in_took)
        begin
            particle_t p;
            p.px  = pos_x;
            p.py  = pos_y;
            p.pz  = pos_z;
            p.lst = last;
            accumulate_particle(p);
            particles_sent++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (factor_q.size() == 0)
            begin
                $error("unexpected result x=%h y=%h z=%h", factor_x, factor_y, factor_z);
                errors++;
            end
            else
            begin
                e = factor_q.pop_front();
                if (factor_x !== e.fx)
                begin
                    $error("factor_x expected %h actual %h", e.fx, factor_x);
                    errors++;
                end
                if (factor_y !== e.fy)
                begin
                    $error("factor_y expected %h actual %h", e.fy, factor_y);
                    errors++;
                end
                if (factor_z !== e.fz)
                begin
                    $error("factor_z expected %h actual %h", e.fz, factor_z);
                    errors++;
                end
            end
        end
        if (in_took || (out_valid && out_ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_MAX);
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver: bursts of requests with random gaps
    always @(negedge clk)
    begin
        particle_t p;
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (particle_q.size() > 0)
            begin
                p = particle_q.pop_front();
                pos_x    <= p.px;
                pos_y    <= p.py;
                pos_z    <= p.pz;
                last     <= p.lst;
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 3) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        rx_cyc++;
        if (rx_cyc % 256 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((rx_cyc % 512) > 320);
        endcase
    end

    task automatic push_particle(input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] z, input logic l);
        particle_t p;
        p.px  = x;
        p.py  = y;
        p.pz  = z;
        p.lst = l;
        particle_q = {particle_q, p};
    endtask

    task automatic drain_all();
        wait (particle_q.size() == 0 && !in_valid && factor_q.size() == 0);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_wave(input logic [11:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        wave_mult = v;
        waves_written++;
    endtask

    // random configurations: mostly short, clustered or uniform positions
    task automatic random_configs(input int n_items);
        int          count;
        int          len;
        bit          clustered;
        int          spread;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bz;
        count = 0;
        while (count < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                              : $urandom_range(1, 24);
            clustered = $urandom_range(0, 1);
            spread    = 1 << $urandom_range(0, 12);
            bx = 16'($urandom);
            by = 16'($urandom);
            bz = 16'($urandom);
            for (int i = 0; i < len; i++)
            begin
                if (clustered)
                    push_particle(16'(bx + $urandom_range(0, spread)),
                                  16'(by + $urandom_range(0, spread)),
                                  16'(bz + $urandom_range(0, spread)), i == len - 1);
                else
                    push_particle(16'($urandom), 16'($urandom), 16'($urandom),
                                  i == len - 1);
            end
            count += len;
        end
    endtask

    initial
    begin
        errors         = 0;
        particles_sent = 0;
        results_seen   = 0;
        waves_written  = 0;
        in_took        = 0;
        burst_left     = 1;
        gap_left       = 0;
        rx_mode        = 0;
        rx_cyc         = 0;
        idle_cycles    = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pos_x     = '0;
        pos_y     = '0;
        pos_z     = '0;
        last      = 1'b0;
        out_ready = 1'b0;
        build_sine();
        wave_mult = 12'd1;
        part_cnt  = 0;
        for (int a = 0; a < 3; a++)
        begin
            cos_acc[a] = 0;
            sin_acc[a] = 0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset wave multiple: extremes, quadrant boundaries, N = 1
        push_particle(16'h0000, 16'hFFFF, 16'h8000, 1'b1);
        push_particle(16'hFFFF, 16'h0000, 16'h4000, 1'b1);
        push_particle(16'h4000, 16'hC000, 16'h000F, 1'b0);
        push_particle(16'h4000, 16'hC000, 16'h0010, 1'b0);
        push_particle(16'h4000, 16'hC000, 16'hFFF0, 1'b1);
        push_particle(16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_particle(16'h8000, 16'h5555, 16'hAAAA, 1'b0);
        push_particle(16'h0000, 16'hAAAA, 16'h5555, 1'b0);
        push_particle(16'h8000, 16'h3FFF, 16'hBFFF, 1'b1);
        for (int i = 0; i < 8; i++)
            push_particle(16'h1234, 16'h1234, 16'h1234, i == 7);
        drain_all();

        write_wave(12'd0);
        push_particle(16'hFFFF, 16'h1234, 16'h8001, 1'b0);
        push_particle(16'h7FFF, 16'hFFFF, 16'h0001, 1'b1);
        random_configs(60);
        drain_all();

        write_wave(12'hFFF);
        push_particle(16'hFFFF, 16'h0001, 16'h8000, 1'b1);
        push_particle(16'h0010, 16'h0011, 16'h7FF0, 1'b1);
        random_configs(120);
        drain_all();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_wave(12'($urandom_range(0, 4095)));
            random_configs(150);
            drain_all();
        end

        write_wave(12'd1);
        random_configs(40);
        drain_all();

        $display("%0d particles, %0d structure factor results, %0d wave multiples written",
                 particles_sent, results_seen, waves_written);
        $display("covered reset and extreme wave multiples, clustered/uniform sets, stalls");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
